// ===== design/ufr_pkg.sv =====
// Package for the ultrasonic frame receiver: status codes, frame constants,
// station numbers and the evaluation record passed from the frame collector.
// Depends on nothing.
package ufr_pkg;

   // frame layout
   localparam int unsigned POS_W = 4;
   localparam logic [POS_W-1:0] FIRST_POS = 4'd0;
   localparam logic [POS_W-1:0] STATION_POS = 4'd1;
   localparam logic [POS_W-1:0] DIST_HIGH_POS = 4'd4;
   localparam logic [POS_W-1:0] DIST_LOW_POS = 4'd5;
   localparam logic [POS_W-1:0] LAST_POS = 4'd9;

   localparam logic [7:0] START_BYTE_RESET = 8'd127;

   // station numbers and their storage slots
   localparam int unsigned STATION_COUNT = 4;
   localparam logic [7:0] STATION_ONE = 8'd1;
   localparam logic [7:0] STATION_TWO = 8'd2;
   localparam logic [7:0] STATION_THREE = 8'd3;
   localparam logic [1:0] SLOT_ONE = 2'd0;
   localparam logic [1:0] SLOT_TWO = 2'd1;
   localparam logic [1:0] SLOT_THREE = 2'd2;
   localparam logic [1:0] SLOT_FOUR = 2'd3;

   typedef enum logic [1:0] {
      STATUS_GOOD      = 2'd0,
      STATUS_BAD_START = 2'd1,
      STATUS_BAD_SUM   = 2'd2
   } status_type;

   // verdict on the byte at hand; meaningful when last is set
   typedef struct packed {
      logic        last;
      status_type  status;
      logic [7:0]  station;
      logic [15:0] distance;
   } frame_eval_type;

endpackage

// ===== design/ufr_frame_collector.sv =====
// Frame collector: tracks byte position, start check, running checksum and
// held fields of the current ten-byte frame, and judges the closing byte.
// Depends on ufr_pkg.
module ufr_frame_collector
   import ufr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_accept,
   input  logic [7:0]     rx_byte,
   input  logic [7:0]     start_byte,
   output frame_eval_type frame
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             start_ok_ff, start_ok_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       station_ff, station_in;
   logic [7:0]       dist_high_ff, dist_high_in;
   logic [7:0]       dist_low_ff, dist_low_in;
   logic             is_last;

   assign is_last = (pos_ff == LAST_POS);

   // judge the closing byte against the held start flag and checksum
   always_comb begin
      frame.last = is_last;
      frame.station = '0;
      frame.distance = '0;
      if (!start_ok_ff) begin
         frame.status = STATUS_BAD_START;
      end else if (rx_byte != sum_ff) begin
         frame.status = STATUS_BAD_SUM;
      end else begin
         frame.status = STATUS_GOOD;
         frame.station = station_ff;
         frame.distance = {dist_high_ff, dist_low_ff};
      end
   end

   // advance position, accumulate the checksum and capture fields
   always_comb begin
      pos_in = pos_ff;
      start_ok_in = start_ok_ff;
      sum_in = sum_ff;
      station_in = station_ff;
      dist_high_in = dist_high_ff;
      dist_low_in = dist_low_ff;
      if (byte_accept) begin
         if (is_last) begin
            pos_in = FIRST_POS;
         end else begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff == FIRST_POS) begin
               start_ok_in = (rx_byte == start_byte);
               sum_in = '0;
            end else begin
               sum_in = sum_ff + rx_byte;
               if (pos_ff == STATION_POS) begin
                  station_in = rx_byte;
               end
               if (pos_ff == DIST_HIGH_POS) begin
                  dist_high_in = rx_byte;
               end
               if (pos_ff == DIST_LOW_POS) begin
                  dist_low_in = rx_byte;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= FIRST_POS;
         start_ok_ff <= 1'b0;
         sum_ff <= '0;
         station_ff <= '0;
         dist_high_ff <= '0;
         dist_low_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         start_ok_ff <= start_ok_in;
         sum_ff <= sum_in;
         station_ff <= station_in;
         dist_high_ff <= dist_high_in;
         dist_low_ff <= dist_low_in;
      end
   end

`ifndef SYNTHESIS
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("frame position beyond the closing byte");

   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      byte_accept && is_last |=> pos_ff == FIRST_POS)
      else $error("position did not wrap after the closing byte");

   a_hold_without_byte: assert property (@(posedge clock) disable iff (reset)
      !byte_accept |=> $stable(pos_ff) && $stable(sum_ff) && $stable(start_ok_ff))
      else $error("frame state moved without an accepted byte");
`endif

endmodule

// ===== design/ultrasonic_frame_receiver.sv =====
// Top level of the ultrasonic frame receiver: handshakes, start byte
// register, per-station distance store and the result register.
// Depends on ufr_pkg and ufr_frame_collector.
module ultrasonic_frame_receiver
   import ufr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // received bytes
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // one result per frame
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_station_id,
   output logic [15:0] rsp_distance,
   output logic [15:0] rsp_dist_station_one,
   output logic [15:0] rsp_dist_station_two,
   output logic [15:0] rsp_dist_station_three,
   output logic [15:0] rsp_dist_station_four,
   // start byte register
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   // The receiver takes one byte per clock and groups every ten bytes into a
   // frame, with no resynchronization. The tenth byte is judged in the same
   // cycle it is accepted, and its result shows on the rsp_ port in the next
   // cycle from the result register. Bytes one through nine never stall; the
   // tenth stalls only while the previous result still sits unaccepted in
   // the result register; bytes flow at one per cycle while results are taken.
   // Writing the start byte takes effect for the next first byte of a frame.

   frame_eval_type frame;
   logic           byte_accept;
   logic           result_load;

   logic [7:0]  start_byte_ff, start_byte_in;
   logic [15:0] dist_ff [STATION_COUNT];
   logic [15:0] dist_in [STATION_COUNT];

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff;
   logic [7:0]  rsp_station_ff;
   logic [15:0] rsp_distance_ff;
   logic [15:0] rsp_dist_ff [STATION_COUNT];

   // stall only the closing byte, and only when the result register is held
   assign req_stall = frame.last && rsp_valid_ff && rsp_stall;
   assign byte_accept = req_valid && !req_stall;
   assign result_load = byte_accept && frame.last;

   ufr_frame_collector u_collector (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_rx_byte),
      .start_byte  (start_byte_ff),
      .frame       (frame)
   );

   assign start_byte_in = csr_write_enable ? csr_write_data : start_byte_ff;

   // route a good frame's distance to its station slot
   always_comb begin
      dist_in = dist_ff;
      if (result_load && frame.status == STATUS_GOOD) begin
         case (frame.station)
            STATION_ONE:   dist_in[SLOT_ONE] = frame.distance;
            STATION_TWO:   dist_in[SLOT_TWO] = frame.distance;
            STATION_THREE: dist_in[SLOT_THREE] = frame.distance;
            default:       dist_in[SLOT_FOUR] = frame.distance;
         endcase
      end
   end

   // result register: load on a closing byte, drop once taken
   always_comb begin
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         dist_ff <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         start_byte_ff <= start_byte_in;
         dist_ff <= dist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, written only on load
   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_status_ff <= frame.status;
         rsp_station_ff <= frame.station;
         rsp_distance_ff <= frame.distance;
         rsp_dist_ff <= dist_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_station_id = rsp_station_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_dist_station_one = rsp_dist_ff[SLOT_ONE];
   assign rsp_dist_station_two = rsp_dist_ff[SLOT_TWO];
   assign rsp_dist_station_three = rsp_dist_ff[SLOT_THREE];
   assign rsp_dist_station_four = rsp_dist_ff[SLOT_FOUR];

`ifndef SYNTHESIS
   a_bad_frame_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_GOOD
      |-> rsp_station_ff == '0 && rsp_distance_ff == '0)
      else $error("bad frame carries station or distance");

   a_good_frame_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_GOOD && rsp_station_ff == STATION_ONE
      |-> rsp_dist_ff[SLOT_ONE] == rsp_distance_ff)
      else $error("station one slot does not match reported distance");

   a_store_only_on_good: assert property (@(posedge clock) disable iff (reset)
      !(result_load && frame.status == STATUS_GOOD)
      |=> $stable(dist_ff[SLOT_ONE]) && $stable(dist_ff[SLOT_TWO])
          && $stable(dist_ff[SLOT_THREE]) && $stable(dist_ff[SLOT_FOUR]))
      else $error("stored distance changed without a good frame");

   a_result_not_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("held transaction dropped");
`endif

endmodule
